### src/rbls_pkg.sv
// ----------------------------------------------------------------------------
// rbls_pkg
// Shared constants and codes for the ring buffer line splitter.
// ----------------------------------------------------------------------------
package rbls_pkg;

    // Request codes on the input channel
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Line terminator
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PUSH_OK   = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_LINE_BYTE = 2'd2,
        ST_NO_LINE   = 2'd3
    } t_status;

endpackage : rbls_pkg

### src/rbls_if.sv
// ----------------------------------------------------------------------------
// rbls_in_if / rbls_out_if
// Valid/ready channels carrying requests into and results out of the splitter.
// ----------------------------------------------------------------------------
interface rbls_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface : rbls_in_if

interface rbls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] line_byte;
    logic       last;

    modport source (output valid, output status, output line_byte, output last,
                     input ready);
    modport sink   (input valid, input status, input line_byte, input last,
                    output ready);
endinterface : rbls_out_if

### src/rbls_mem.sv
// ----------------------------------------------------------------------------
// rbls_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rbls_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data until the next read
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : rbls_mem

### src/rbls_ctrl.sv
// ----------------------------------------------------------------------------
// rbls_ctrl
// Pointer and count keeping, pop sequencing and the result register.
// ----------------------------------------------------------------------------
module rbls_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rbls_in_if.sink       i_in,
    rbls_out_if.source    o_out,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data
);
    import rbls_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    localparam logic [AW-1:0] LAST_POS = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    t_state        r_state;
    logic [AW-1:0] r_wr_pos;
    logic [AW-1:0] r_rd_pos;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_nl_cnt;
    logic          r_out_valid;
    t_status       r_out_status;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic out_free;
    logic in_ready;
    logic in_acc;
    logic is_full;
    logic rd_is_nl;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos);
        return (pos == LAST_POS) ? '0 : pos + AW'(1);
    endfunction

    always_comb begin
        out_free = !r_out_valid || o_out.ready;
        in_ready = (r_state == S_IDLE) && out_free;
        in_acc   = i_in.valid && in_ready;
        is_full  = (r_fill == FULL_CNT);
        rd_is_nl = (i_rd_data == NEWLINE_BYTE);
    end

    assign i_in.ready = in_ready;

    assign o_wr_en   = in_acc && (i_in.action == ACT_PUSH) && !is_full;
    assign o_wr_addr = r_wr_pos;
    assign o_wr_data = i_in.data_byte;
    // issue the first read on pop acceptance, then one per loaded byte
    assign o_rd_en   = (in_acc && (i_in.action == ACT_POP) && (r_nl_cnt != '0))
                     || ((r_state == S_POP) && out_free && !rd_is_nl);
    assign o_rd_addr = r_rd_pos;

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.line_byte = r_out_byte;
    assign o_out.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_fill      <= '0;
            r_nl_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_byte  <= '0;
                        r_out_last  <= 1'b1;
                        if (i_in.action == ACT_PUSH) begin
                            r_out_valid <= 1'b1;
                            if (is_full) begin
                                r_out_status <= ST_OVERFLOW;
                            end else begin
                                r_out_status <= ST_PUSH_OK;
                                r_wr_pos     <= advance(r_wr_pos);
                                r_fill       <= r_fill + CW'(1);
                                if (i_in.data_byte == NEWLINE_BYTE) begin
                                    r_nl_cnt <= r_nl_cnt + CW'(1);
                                end
                            end
                        end else if (r_nl_cnt == '0) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_NO_LINE;
                        end else begin
                            // first byte comes back next cycle
                            r_out_valid <= 1'b0;
                            r_rd_pos    <= advance(r_rd_pos);
                            r_fill      <= r_fill - CW'(1);
                            r_state     <= S_POP;
                        end
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_LINE_BYTE;
                        r_out_byte   <= i_rd_data;
                        r_out_last   <= rd_is_nl;
                        if (rd_is_nl) begin
                            r_nl_cnt <= r_nl_cnt - CW'(1);
                            r_state  <= S_IDLE;
                        end else begin
                            r_rd_pos <= advance(r_rd_pos);
                            r_fill   <= r_fill - CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count exceeds capacity");

    a_nl_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_nl_cnt <= r_fill))
        else $error("more newlines than stored bytes");

    a_pop_has_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_nl_cnt != '0))
        else $error("line pop in progress with no newline stored");

    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.action == ACT_POP) && (r_nl_cnt != '0))
        |=> ((r_state == S_POP) && !r_out_valid))
        else $error("pop with a line did not start the read sequence");

    a_no_write_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !o_wr_en)
        else $error("store written during a line pop");

endmodule : rbls_ctrl

### src/ring_buffer_line_splitter_top.sv
// A byte ring of CAPACITY entries that collects a text stream and returns it as
// complete newline-terminated lines. Each input transaction is a push (append
// one byte) or a pop (remove the oldest complete line). A push always yields
// one result, accepted or overflow (byte dropped when the ring is full), and
// pushes can stream at one byte per clock while the sink is ready. A pop with
// no complete line stored yields a single no-line result. A pop with a line
// of L bytes (newline included) first reads the byte store, then yields L
// line-byte results, one byte per cycle while the sink is ready, with last
// set on the newline. The byte store has a single read port with registered
// read data; no new request is taken while a line is being emitted. Results go
// through an output register, so a stalled sink holds the pipeline without
// losing data. The store is not cleared at reset; only bytes that were pushed
// are ever read back.
// ----------------------------------------------------------------------------
// ring_buffer_line_splitter_top
// Top level: byte store memory plus pointer/count control.
// ----------------------------------------------------------------------------
module ring_buffer_line_splitter_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbls_in_if.sink     i_in,
    rbls_out_if.source  o_out
);
    import rbls_pkg::*;

    // pointer width covers entries 0..CAPACITY-1, count width covers CAPACITY
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Control: accept transactions, advance pointers, sequence line pops
    rbls_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Byte store: write on push, read one byte a cycle during a pop while the sink is ready
    rbls_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Catch the newline definition drifting from the code 0x0A
    a_nl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (wr_data == NEWLINE_BYTE)) |-> (i_in.data_byte == 8'h0A))
        else $error("newline code mismatch on store write");

endmodule : ring_buffer_line_splitter_top
